@@ sv/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg: shared constants for the 3d segment distance pipeline
// Fixed port widths and square root sizing.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // fixed field widths
  localparam int EPS_W  = 16;
  localparam int DIST_W = 26;

  // bitwise square root: operand width and step count
  localparam int ROOT_W    = 64;
  localparam int ROOT_STEP = 32;

endpackage

@@ sv/segment_segment_distance_3d.sv @@
// ----------------------------------------------------------------------------
// segment_segment_distance_3d: closest distance between two 3d segments
// Dot products, determinant, clamped parameters, restoring division and a
// bitwise square root, all in one stall-controlled pipeline.
// ----------------------------------------------------------------------------
//
//   channel  | handshake          | request
//   ---------+--------------------+------------------------------------------
//   in_      | in_valid/in_stall  | twelve endpoint coordinates
//   out_     | out_valid/out_stall| out_distance_q8
//   cfg_     | cfg_valid/cfg_ready| cfg_eps_threshold
//
// One request enters per cycle while in_stall is low. The pipeline has
// 13 + FRACTION_BITS + 32 register stages: seven front stages, one divider
// stage per fraction bit, five length stages, one stage per square root step
// and the output register. An accepting edge loads the first stage, or the
// skid buffer when the pipeline holds. The whole pipeline advances
// together whenever the output register is empty or being taken; a one-entry
// skid buffer at the input keeps in_stall registered and takes a request
// while a result waits.
// Synchronous reset clears the valid bits, the skid buffer and the threshold.
//
module segment_segment_distance_3d #(
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_first_start_x,
  input  logic signed [COORD_BITS-1:0]  in_first_start_y,
  input  logic signed [COORD_BITS-1:0]  in_first_start_z,
  input  logic signed [COORD_BITS-1:0]  in_first_end_x,
  input  logic signed [COORD_BITS-1:0]  in_first_end_y,
  input  logic signed [COORD_BITS-1:0]  in_first_end_z,
  input  logic signed [COORD_BITS-1:0]  in_second_start_x,
  input  logic signed [COORD_BITS-1:0]  in_second_start_y,
  input  logic signed [COORD_BITS-1:0]  in_second_start_z,
  input  logic signed [COORD_BITS-1:0]  in_second_end_x,
  input  logic signed [COORD_BITS-1:0]  in_second_end_y,
  input  logic signed [COORD_BITS-1:0]  in_second_end_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ssd_pkg::DIST_W-1:0]    out_distance_q8,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssd_pkg::EPS_W-1:0]     cfg_eps_threshold
);
  import ssd_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int FB   = FRACTION_BITS;
  localparam int DW   = CB + 1;
  localparam int PRW  = 2 * DW;
  localparam int DOTW = PRW + 2;
  localparam int MW   = 2 * DOTW;
  localparam int NW   = MW + 1;
  localparam int AW   = DOTW + 1;
  localparam int FCW  = FB + 1;
  localparam int PW   = DW + FB + 2;
  localparam int MGW  = PW - 1;
  localparam int H    = (MGW + 1) / 2;
  localparam int HW   = MGW - H;
  localparam int SQW  = 2 * MGW;
  localparam int SUMW = SQW + 2;
  localparam int SH   = 2 * FB - 16;
  localparam int NGEO = 7 + FB;
  localparam int NSTG = 7 + FB + 5 + ROOT_STEP + 1;

  typedef logic signed [DW-1:0]   dif_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic signed [MW-1:0]   mul_t;
  typedef logic signed [NW-1:0]   num_t;
  typedef logic signed [AW-1:0]   aw_t;
  typedef logic signed [CB-1:0]   crd_t;

  typedef struct packed {
    dif_t [2:0] u;
    dif_t [2:0] v;
    dif_t [2:0] w;
  } geo_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [NW-1:0] den;
    logic [FB-1:0] q;
    logic          zero;
    logic          one;
  } dvs_t;

  // one restoring division step
  function automatic dvs_t dv_step(dvs_t d);
    logic [NW:0] rs;
    logic [NW:0] dn;
    logic        ge;
    dvs_t        r;
    rs    = {d.rem, 1'b0};
    dn    = {1'b0, d.den};
    ge    = (rs >= dn);
    r     = d;
    r.rem = ge ? NW'(rs - dn) : NW'(rs);
    r.q   = {d.q[FB-2:0], ge};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration
  logic [EPS_W-1:0] eps_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= '0;
    end else if (cfg_valid) begin
      eps_r <= cfg_eps_threshold;
    end
  end

  num_t eps_n;
  aw_t  eps_a;
  assign eps_n = $signed(NW'(eps_r));
  assign eps_a = $signed(AW'(eps_r));

  // ---------------------------------------------------------------------------
  // input skid buffer and global advance
  logic            skid_vld_r;
  crd_t            skid_r [12];
  crd_t            pin    [12];
  crd_t            ent    [12];
  logic            ent_vld;
  logic            in_acc;
  logic            adv;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;

  assign pin[0]  = in_first_start_x;
  assign pin[1]  = in_first_start_y;
  assign pin[2]  = in_first_start_z;
  assign pin[3]  = in_first_end_x;
  assign pin[4]  = in_first_end_y;
  assign pin[5]  = in_first_end_z;
  assign pin[6]  = in_second_start_x;
  assign pin[7]  = in_second_start_y;
  assign pin[8]  = in_second_start_z;
  assign pin[9]  = in_second_end_x;
  assign pin[10] = in_second_end_y;
  assign pin[11] = in_second_end_z;

  assign adv      = !vld_r[NSTG-1] || !out_stall;
  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid && !skid_vld_r;
  assign ent_vld  = skid_vld_r || in_valid;
  assign vld_nxt  = {vld_r[NSTG-2:0], ent_vld};

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      ent[i] = skid_vld_r ? skid_r[i] : pin[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else if (adv) begin
      skid_vld_r <= 1'b0;
    end else if (in_acc) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_acc) begin
      skid_r <= pin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: difference vectors
  geo_t geo_r   [NGEO];
  geo_t geo_nxt [NGEO];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      geo_nxt[0].u[i] = DW'(ent[3 + i]) - DW'(ent[i]);
      geo_nxt[0].v[i] = DW'(ent[9 + i]) - DW'(ent[6 + i]);
      geo_nxt[0].w[i] = DW'(ent[i]) - DW'(ent[6 + i]);
    end
    for (int k = 1; k < NGEO; k++) begin
      geo_nxt[k] = geo_r[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: five dot products
  dot_t uu2_r, vv2_r, uv2_r, uw2_r, vw2_r;
  dot_t uu2_nxt, vv2_nxt, uv2_nxt, uw2_nxt, vw2_nxt;
  geo_t g1;

  assign g1 = geo_r[0];

  always_comb begin
    uu2_nxt = '0;
    vv2_nxt = '0;
    uv2_nxt = '0;
    uw2_nxt = '0;
    vw2_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      uu2_nxt = uu2_nxt + DOTW'(PRW'(g1.u[i]) * PRW'(g1.u[i]));
      vv2_nxt = vv2_nxt + DOTW'(PRW'(g1.v[i]) * PRW'(g1.v[i]));
      uv2_nxt = uv2_nxt + DOTW'(PRW'(g1.u[i]) * PRW'(g1.v[i]));
      uw2_nxt = uw2_nxt + DOTW'(PRW'(g1.u[i]) * PRW'(g1.w[i]));
      vw2_nxt = vw2_nxt + DOTW'(PRW'(g1.v[i]) * PRW'(g1.w[i]));
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: cross products of the dot terms
  mul_t m_uuvv_r, m_uvuv_r, m_uvvw_r, m_vvuw_r, m_uuvw_r, m_uvuw_r;
  mul_t m_uuvv_nxt, m_uvuv_nxt, m_uvvw_nxt, m_vvuw_nxt, m_uuvw_nxt, m_uvuw_nxt;
  dot_t uu3_r, vv3_r, uv3_r, uw3_r, vw3_r;

  assign m_uuvv_nxt = MW'(uu2_r) * MW'(vv2_r);
  assign m_uvuv_nxt = MW'(uv2_r) * MW'(uv2_r);
  assign m_uvvw_nxt = MW'(uv2_r) * MW'(vw2_r);
  assign m_vvuw_nxt = MW'(vv2_r) * MW'(uw2_r);
  assign m_uuvw_nxt = MW'(uu2_r) * MW'(vw2_r);
  assign m_uvuw_nxt = MW'(uv2_r) * MW'(uw2_r);

  // ---------------------------------------------------------------------------
  // stage 4: determinant and raw numerators
  num_t det4_r, sn4_r, tn4_r;
  num_t det4_nxt, sn4_nxt, tn4_nxt;
  dot_t uu4_r, vv4_r, uv4_r, uw4_r, vw4_r;

  assign det4_nxt = NW'(m_uuvv_r) - NW'(m_uvuv_r);
  assign sn4_nxt  = NW'(m_uvvw_r) - NW'(m_vvuw_r);
  assign tn4_nxt  = NW'(m_uuvw_r) - NW'(m_uvuw_r);

  // ---------------------------------------------------------------------------
  // stage 5: parallel test and s clamp
  num_t sn5_r, sd5_r, tn5_r, td5_r;
  num_t sn5_nxt, sd5_nxt, tn5_nxt, td5_nxt;
  dot_t uu5_r, uv5_r, uw5_r;

  always_comb begin
    sd5_nxt = det4_r;
    td5_nxt = det4_r;
    sn5_nxt = sn4_r;
    tn5_nxt = tn4_r;
    priority if (!(eps_n < det4_r)) begin
      sn5_nxt = '0;
      sd5_nxt = NW'(1);
      tn5_nxt = NW'(vw4_r);
      td5_nxt = NW'(vv4_r);
    end else if (!(eps_n < sn4_r)) begin
      sn5_nxt = '0;
      tn5_nxt = NW'(vw4_r);
      td5_nxt = NW'(vv4_r);
    end else if (det4_r < sn4_r) begin
      sn5_nxt = det4_r;
      tn5_nxt = NW'(AW'(vw4_r) + AW'(uv4_r));
      td5_nxt = NW'(vv4_r);
    end else begin
      sn5_nxt = sn4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: t clamp with s reselection
  num_t sn6_r, sd6_r, tn6_r, td6_r;
  num_t sn6_nxt, sd6_nxt, tn6_nxt, td6_nxt;
  aw_t  a6, nuw6, uu6, uw6;

  assign a6   = AW'(uv5_r) - AW'(uw5_r);
  assign uw6  = AW'(uw5_r);
  assign nuw6 = -uw6;
  assign uu6  = AW'(uu5_r);

  always_comb begin
    sn6_nxt = sn5_r;
    sd6_nxt = sd5_r;
    tn6_nxt = tn5_r;
    td6_nxt = td5_r;
    priority if (td5_r < tn5_r) begin
      tn6_nxt = td5_r;
      priority if (a6 <= eps_a) begin
        sn6_nxt = '0;
      end else if (a6 > uu6) begin
        sn6_nxt = sd5_r;
      end else begin
        sn6_nxt = NW'(a6);
        sd6_nxt = NW'(uu6);
      end
    end else if (!(eps_n < tn5_r)) begin
      tn6_nxt = '0;
      priority if (uw6 >= eps_a) begin
        sn6_nxt = '0;
      end else if (nuw6 > uu6) begin
        sn6_nxt = sd5_r;
      end else begin
        sn6_nxt = NW'(nuw6);
        sd6_nxt = NW'(uu6);
      end
    end else begin
      tn6_nxt = tn5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7 and divider stages: special cases, then one quotient bit per stage
  dvs_t ds_r [FB+1];
  dvs_t dt_r [FB+1];
  dvs_t ds_nxt [FB+1];
  dvs_t dt_nxt [FB+1];

  always_comb begin
    ds_nxt[0].rem  = sn6_r;
    ds_nxt[0].den  = sd6_r;
    ds_nxt[0].q    = '0;
    ds_nxt[0].zero = ((sn6_r <= eps_n) && (sn6_r >= -eps_n)) ||
                     !(sd6_r > 0) || !(sn6_r > 0);
    ds_nxt[0].one  = !ds_nxt[0].zero && !(sn6_r < sd6_r);
    dt_nxt[0].rem  = tn6_r;
    dt_nxt[0].den  = td6_r;
    dt_nxt[0].q    = '0;
    dt_nxt[0].zero = ((tn6_r <= eps_n) && (tn6_r >= -eps_n)) ||
                     !(td6_r > 0) || !(tn6_r > 0);
    dt_nxt[0].one  = !dt_nxt[0].zero && !(tn6_r < td6_r);
    for (int j = 1; j <= FB; j++) begin
      ds_nxt[j] = dv_step(ds_r[j-1]);
      dt_nxt[j] = dv_step(dt_r[j-1]);
    end
  end

  // ---------------------------------------------------------------------------
  // length stage 1: closest-approach vector
  logic [FCW-1:0]         sc, tc;
  logic signed [PW-1:0]   p_r   [3];
  logic signed [PW-1:0]   p_nxt [3];
  geo_t                   gl;

  assign gl = geo_r[NGEO-1];

  always_comb begin
    priority if (ds_r[FB].zero) sc = '0;
    else if (ds_r[FB].one)      sc = FCW'(1) << FB;
    else                        sc = {1'b0, ds_r[FB].q};
    priority if (dt_r[FB].zero) tc = '0;
    else if (dt_r[FB].one)      tc = FCW'(1) << FB;
    else                        tc = {1'b0, dt_r[FB].q};
    for (int i = 0; i < 3; i++) begin
      p_nxt[i] = (PW'(gl.w[i]) <<< FB)
               + PW'(gl.u[i]) * PW'($signed({1'b0, sc}))
               - PW'(gl.v[i]) * PW'($signed({1'b0, tc}));
    end
  end

  // length stage 2: magnitudes
  logic [MGW-1:0] mag_r   [3];
  logic [MGW-1:0] mag_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = MGW'(unsigned'(p_r[i] < 0 ? -p_r[i] : p_r[i]));
    end
  end

  // length stage 3: half-width partial products
  logic [2*H-1:0]  ll_r [3], ll_nxt [3];
  logic [H+HW-1:0] lh_r [3], lh_nxt [3];
  logic [2*HW-1:0] hh_r [3], hh_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ll_nxt[i] = (2*H)'(mag_r[i][H-1:0]) * (2*H)'(mag_r[i][H-1:0]);
      lh_nxt[i] = (H+HW)'(mag_r[i][H-1:0]) * (H+HW)'(mag_r[i][MGW-1:H]);
      hh_nxt[i] = (2*HW)'(mag_r[i][MGW-1:H]) * (2*HW)'(mag_r[i][MGW-1:H]);
    end
  end

  // length stage 4: squares
  logic [SQW-1:0] sq_r [3], sq_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = SQW'(ll_r[i]) + (SQW'(lh_r[i]) << (H + 1)) + (SQW'(hh_r[i]) << (2 * H));
    end
  end

  // length stage 5: sum, scale to 16 fractional bits, saturate to root width
  logic [SUMW-1:0]        sum5;
  logic [SUMW+ROOT_W-1:0] ext5;
  logic [ROOT_W-1:0]      rx_r   [ROOT_STEP+1];
  logic [ROOT_W-1:0]      rres_r [ROOT_STEP+1];
  logic [ROOT_W-1:0]      rx_nxt   [ROOT_STEP+1];
  logic [ROOT_W-1:0]      rres_nxt [ROOT_STEP+1];

  assign sum5 = SUMW'(sq_r[0]) + SUMW'(sq_r[1]) + SUMW'(sq_r[2]);
  assign ext5 = (SUMW+ROOT_W)'(sum5) >> SH;

  // square root steps, one result bit per stage
  always_comb begin
    logic [ROOT_W-1:0] bit_c;
    logic [ROOT_W-1:0] trial;
    rx_nxt[0]   = (|ext5[SUMW+ROOT_W-1:ROOT_W]) ? '1 : ext5[ROOT_W-1:0];
    rres_nxt[0] = '0;
    for (int k = 1; k <= ROOT_STEP; k++) begin
      bit_c = ROOT_W'(1) << (ROOT_W - 2 * k);
      trial = rres_r[k-1] + bit_c;
      if (rx_r[k-1] >= trial) begin
        rx_nxt[k]   = rx_r[k-1] - trial;
        rres_nxt[k] = (rres_r[k-1] >> 1) + bit_c;
      end else begin
        rx_nxt[k]   = rx_r[k-1];
        rres_nxt[k] = rres_r[k-1] >> 1;
      end
    end
  end

  // output register with saturation
  logic [DIST_W-1:0] dist_r, dist_nxt;

  assign dist_nxt = (|rres_r[ROOT_STEP][ROOT_W-1:DIST_W]) ? '1
                  : rres_r[ROOT_STEP][DIST_W-1:0];

  assign out_valid       = vld_r[NSTG-1];
  assign out_distance_q8 = dist_r;

  // ---------------------------------------------------------------------------
  // payload registers, all moving on the common advance
  always_ff @(posedge clk) begin
    if (adv) begin
      geo_r    <= geo_nxt;
      uu2_r    <= uu2_nxt;
      vv2_r    <= vv2_nxt;
      uv2_r    <= uv2_nxt;
      uw2_r    <= uw2_nxt;
      vw2_r    <= vw2_nxt;
      m_uuvv_r <= m_uuvv_nxt;
      m_uvuv_r <= m_uvuv_nxt;
      m_uvvw_r <= m_uvvw_nxt;
      m_vvuw_r <= m_vvuw_nxt;
      m_uuvw_r <= m_uuvw_nxt;
      m_uvuw_r <= m_uvuw_nxt;
      uu3_r    <= uu2_r;
      vv3_r    <= vv2_r;
      uv3_r    <= uv2_r;
      uw3_r    <= uw2_r;
      vw3_r    <= vw2_r;
      det4_r   <= det4_nxt;
      sn4_r    <= sn4_nxt;
      tn4_r    <= tn4_nxt;
      uu4_r    <= uu3_r;
      vv4_r    <= vv3_r;
      uv4_r    <= uv3_r;
      uw4_r    <= uw3_r;
      vw4_r    <= vw3_r;
      sn5_r    <= sn5_nxt;
      sd5_r    <= sd5_nxt;
      tn5_r    <= tn5_nxt;
      td5_r    <= td5_nxt;
      uu5_r    <= uu4_r;
      uv5_r    <= uv4_r;
      uw5_r    <= uw4_r;
      sn6_r    <= sn6_nxt;
      sd6_r    <= sd6_nxt;
      tn6_r    <= tn6_nxt;
      td6_r    <= td6_nxt;
      ds_r     <= ds_nxt;
      dt_r     <= dt_nxt;
      p_r      <= p_nxt;
      mag_r    <= mag_nxt;
      ll_r     <= ll_nxt;
      lh_r     <= lh_nxt;
      hh_r     <= hh_nxt;
      sq_r     <= sq_nxt;
      rx_r     <= rx_nxt;
      rres_r   <= rres_nxt;
      dist_r   <= dist_nxt;
    end
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for segment_segment_distance_3d
// Drives directed segment pairs and random bursts against a stalling receiver,
// predicts each distance with a bit-true model and checks results in order.
// ----------------------------------------------------------------------------
class distance_board;
  bit [25:0] dist_q[$];
  int        mismatch_cnt;

  // note the expected distance of an accepted request
  function void note_request(bit [25:0] d);
    dist_q.insert(dist_q.size(), d);
  endfunction

  // check one result against the oldest expectation
  function void check_result(bit [25:0] got);
    bit [25:0] want;
    if (dist_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("unexpected result distance=%0d", got);
      return;
    end
    want = dist_q.pop_front();
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("distance mismatch: expected %0d actual %0d", want, got);
    end
  endfunction
endclass

module tb;
  import ssd_pkg::*;

  localparam int CB       = 16;
  localparam int FB       = 24;
  localparam int LATENCY  = 13 + FB + 32;
  localparam int WD_LIMIT = 20000;

  typedef logic signed [CB-1:0] coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t pt [12];
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DIST_W-1:0] out_distance_q8;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [EPS_W-1:0] cfg_eps_threshold = '0;

  distance_board board = new();
  logic [EPS_W-1:0] eps_reg = '0;
  int idle_cycles = 0;
  bit stall_en = 1'b1;
  int stall_mode = 0;

  initial for (int i = 0; i < 12; i++) pt[i] = '0;

  always #6 clk = ~clk;

  segment_segment_distance_3d #(.COORD_BITS(CB), .FRACTION_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_first_start_x(pt[0]), .in_first_start_y(pt[1]), .in_first_start_z(pt[2]),
    .in_first_end_x(pt[3]), .in_first_end_y(pt[4]), .in_first_end_z(pt[5]),
    .in_second_start_x(pt[6]), .in_second_start_y(pt[7]),
    .in_second_start_z(pt[8]), .in_second_end_x(pt[9]),
    .in_second_end_y(pt[10]), .in_second_end_z(pt[11]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance_q8(out_distance_q8), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_eps_threshold(cfg_eps_threshold)
  );

  // fraction num/den in [0,1] with FB fractional bits, truncated
  function automatic logic [63:0] to_fraction(logic signed [127:0] num,
                                              logic signed [127:0] den);
    logic signed [127:0] r;
    logic [63:0] q;
    r = num;
    q = '0;
    if (den <= 0 || num <= 0) return '0;
    if (num >= den) return 64'd1 << FB;
    for (int i = 0; i < FB; i++) begin
      r = r <<< 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // bitwise floor square root of a 64-bit value
  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // closest distance between the two segments in q8
  function automatic logic [25:0] seg_distance(coord_t c [12], logic [15:0] eps_u);
    logic signed [63:0] u [3], v [3], w [3], p [3];
    logic signed [63:0] uu, vv, uv, uw, vw, e, a;
    logic signed [127:0] eps, det, sn, sd, tn, td, sum;
    logic [63:0] sc, tc, x, d;
    e = {48'd0, eps_u};
    eps = e;
    for (int i = 0; i < 3; i++) begin
      u[i] = 64'(c[3+i]) - 64'(c[i]);
      v[i] = 64'(c[9+i]) - 64'(c[6+i]);
      w[i] = 64'(c[i]) - 64'(c[6+i]);
    end
    uu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
    vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    uv = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    uw = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
    vw = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
    det = 128'(uu) * 128'(vv) - 128'(uv) * 128'(uv);
    sd = det;
    td = det;
    // near-parallel or degenerate pair
    if (det <= eps) begin
      sn = 0; sd = 1; tn = vw; td = vv;
    end else begin
      sn = 128'(uv) * 128'(vw) - 128'(vv) * 128'(uw);
      tn = 128'(uu) * 128'(vw) - 128'(uv) * 128'(uw);
      if (sn <= eps) begin
        sn = 0; tn = vw; td = vv;
      end else if (sn > sd) begin
        sn = sd; tn = 128'(vw + uv); td = vv;
      end
    end
    // clamp t, then reselect s
    if (tn > td) begin
      tn = td;
      a = uv - uw;
      if (a <= e) sn = 0;
      else if (a > uu) sn = sd;
      else begin sn = a; sd = uu; end
    end else if (tn <= eps) begin
      tn = 0;
      if (uw >= e) sn = 0;
      else if (-uw > uu) sn = sd;
      else begin sd = uu; sn = -uw; end
    end
    sc = (sn <= eps && sn >= -eps) ? 64'd0 : to_fraction(sn, sd);
    tc = (tn <= eps && tn >= -eps) ? 64'd0 : to_fraction(tn, td);
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = (w[i] <<< FB) + u[i] * $signed(sc) - v[i] * $signed(tc);
      sum = sum + 128'(p[i]) * 128'(p[i]);
    end
    sum = sum >>> (2*FB - 16);
    x = (sum[127:64] != 0) ? '1 : sum[63:0];
    d = floor_root(x);
    if (d > 64'h3FF_FFFF) d = 64'h3FF_FFFF;
    return d[25:0];
  endfunction

  // write the threshold register while the block is idle
  task automatic write_eps(logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_eps_threshold <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eps_reg = val;
  endtask

  // present one pair and hold it until accepted
  task automatic send_pair(coord_t c [12]);
    for (int i = 0; i < 12; i++) pt[i] <= c[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_request(seg_distance(c, eps_reg));
  endtask

  task automatic go_idle(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (board.dist_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom());
      1: return coord_t'($urandom_range(0, 40)) - 16'sd20;
      2: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      default: return coord_t'($urandom_range(0, 2000)) - 16'sd1000;
    endcase
  endfunction

  // random burst of pairs; some parallel or point segments
  task automatic random_phase(int count);
    coord_t c [12];
    int burst, mode;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        go_idle($urandom_range(0, 6));
        burst = $urandom_range(1, 30);
      end
      burst--;
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 12; i++) c[i] = rnd_coord(mode);
      case ($urandom_range(0, 7))
        0: for (int i = 0; i < 3; i++) c[9+i] = c[6+i] + (c[3+i] - c[i]);
        1: for (int i = 0; i < 3; i++) c[3+i] = c[i];
        2: for (int i = 0; i < 3; i++) c[9+i] = c[6+i];
        default: ;
      endcase
      send_pair(c);
    end
  endtask

  task automatic directed_phase;
    coord_t c [12];
    for (int k = 0; k < 20; k++) begin
      for (int i = 0; i < 12; i++) c[i] = '0;
      case (k)
        0: ;
        1: for (int i = 0; i < 12; i++) c[i] = 16'sh7FFF;
        2: for (int i = 0; i < 12; i++) c[i] = 16'sh8000;
        3: for (int i = 0; i < 12; i++) c[i] = i[0] ? 16'sh7FFF : 16'sh8000;
        4: for (int i = 0; i < 12; i++) c[i] = (i < 6) ? 16'sh8000 : 16'sh7FFF;
        5: begin c[3] = 10; c[6] = 5; c[7] = 3; c[9] = 5; c[10] = 3; c[11] = 7; end
        6: begin c[3] = 10; c[7] = 4; c[9] = 10; c[10] = 4; end
        7: begin c[3] = 10; c[6] = 20; c[7] = 1; c[9] = 30; c[10] = 1; end
        8: begin c[3] = 10; c[6] = -20; c[7] = 1; c[9] = -30; c[10] = 1; end
        9: begin c[3] = 1; c[7] = 1; c[10] = 1; c[11] = 1; end
        10: begin c[3] = 100; c[6] = 50; c[7] = -5; c[8] = 2; c[10] = 9; c[11] = 2; end
        11: begin c[3] = 100; c[4] = 1; c[6] = 200; c[9] = 300; c[10] = 2; end
        12: begin c[6] = 3; c[7] = 4; c[8] = 5; c[9] = 3; c[10] = 4; c[11] = 5; end
        13: begin c[3] = 7; c[6] = 3; c[7] = -2; c[9] = 3; c[10] = 9; end
        14: begin c[0] = 16'sh8000; c[3] = 16'sh7FFF; c[7] = 16'sh8000; c[10] = 16'sh7FFF; end
        15: begin c[3] = 100; c[6] = -5; c[7] = 1; c[9] = -5; c[10] = 50; end
        16: begin c[3] = 100; c[6] = 105; c[7] = 1; c[9] = 105; c[10] = 50; end
        17: for (int i = 0; i < 12; i++) c[i] = coord_t'(16'h5555 << i[0]);
        18: for (int i = 0; i < 12; i++) c[i] = coord_t'(16'hAAAA >> i[0]);
        default: begin c[3] = 2; c[4] = 1; c[6] = 1; c[7] = 1; c[9] = 1; c[10] = 2; end
      endcase
      send_pair(c);
    end
  endtask

  // receiver stall pattern, checks every accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_result(out_distance_q8);
      stall_mode <= ($urandom_range(0, 63) == 0) ? $urandom_range(0, 3) : stall_mode;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= stall_en && ($urandom_range(0, 3) == 0);
        2: out_stall <= stall_en && ($urandom_range(0, 1) == 0);
        default: out_stall <= stall_en && ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_phase();
    drain();
    write_eps(16'hFFFF);
    directed_phase();
    random_phase(60);
    drain();
    write_eps(16'd1);
    random_phase(150);
    drain();
    write_eps(16'(1 << $urandom_range(0, 15)));
    random_phase(120);
    drain();
    write_eps(16'd0);
    random_phase(150);
    drain();
    stall_en = 1'b0;
    repeat (10) @(posedge clk);
    if (board.mismatch_cnt == 0 && board.dist_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
